>>> src/c2u_pkg.sv
package c2u_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 14;   // widest code point in the table is U+2122

    localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
    localparam logic [CP_W-1:0]   CP_TWO_MAX  = 14'h0800;

    typedef logic [1:0] t_byte_cnt;

    localparam t_byte_cnt CNT_ONE   = 2'd1;
    localparam t_byte_cnt CNT_TWO   = 2'd2;
    localparam t_byte_cnt CNT_THREE = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b2;
        t_byte_cnt         cnt;
    } t_utf8_seq;

    // Code points of bytes 0x80..0xFF; position 0x98 is unassigned and maps to '?'.
    localparam logic [CP_W-1:0] HI_MAP [128] = '{
        14'h0402, 14'h0403, 14'h201A, 14'h0453, 14'h201E, 14'h2026, 14'h2020, 14'h2021,
        14'h20AC, 14'h2030, 14'h0409, 14'h2039, 14'h040A, 14'h040C, 14'h040B, 14'h040F,
        14'h0452, 14'h2018, 14'h2019, 14'h201C, 14'h201D, 14'h2022, 14'h2013, 14'h2014,
        14'h003F, 14'h2122, 14'h0459, 14'h203A, 14'h045A, 14'h045C, 14'h045B, 14'h045F,
        14'h00A0, 14'h040E, 14'h045E, 14'h0408, 14'h00A4, 14'h0490, 14'h00A6, 14'h00A7,
        14'h0401, 14'h00A9, 14'h0404, 14'h00AB, 14'h00AC, 14'h00AD, 14'h00AE, 14'h0407,
        14'h00B0, 14'h00B1, 14'h0406, 14'h0456, 14'h0491, 14'h00B5, 14'h00B6, 14'h00B7,
        14'h0451, 14'h2116, 14'h0454, 14'h00BB, 14'h0458, 14'h0405, 14'h0455, 14'h0457,
        14'h0410, 14'h0411, 14'h0412, 14'h0413, 14'h0414, 14'h0415, 14'h0416, 14'h0417,
        14'h0418, 14'h0419, 14'h041A, 14'h041B, 14'h041C, 14'h041D, 14'h041E, 14'h041F,
        14'h0420, 14'h0421, 14'h0422, 14'h0423, 14'h0424, 14'h0425, 14'h0426, 14'h0427,
        14'h0428, 14'h0429, 14'h042A, 14'h042B, 14'h042C, 14'h042D, 14'h042E, 14'h042F,
        14'h0430, 14'h0431, 14'h0432, 14'h0433, 14'h0434, 14'h0435, 14'h0436, 14'h0437,
        14'h0438, 14'h0439, 14'h043A, 14'h043B, 14'h043C, 14'h043D, 14'h043E, 14'h043F,
        14'h0440, 14'h0441, 14'h0442, 14'h0443, 14'h0444, 14'h0445, 14'h0446, 14'h0447,
        14'h0448, 14'h0449, 14'h044A, 14'h044B, 14'h044C, 14'h044D, 14'h044E, 14'h044F
    };

    // Map one CP1251 byte to its UTF-8 byte sequence, lead byte in b0.
    function automatic t_utf8_seq f_encode(logic [BYTE_W-1:0] byte_in);
        t_utf8_seq        seq;
        logic [CP_W-1:0]  cp;
        seq = '0;
        if (byte_in < ASCII_LIMIT) begin
            cp = {{(CP_W-BYTE_W){1'b0}}, byte_in};
        end else begin
            cp = HI_MAP[byte_in[6:0]];
        end
        if (cp < CP_W'(ASCII_LIMIT)) begin
            seq.b0  = cp[7:0];
            seq.cnt = CNT_ONE;
        end else if (cp < CP_TWO_MAX) begin
            seq.b0  = {3'b110, cp[10:6]};
            seq.b1  = {2'b10, cp[5:0]};
            seq.cnt = CNT_TWO;
        end else begin
            seq.b0  = {4'b1110, 2'b00, cp[13:12]};
            seq.b1  = {2'b10, cp[11:6]};
            seq.b2  = {2'b10, cp[5:0]};
            seq.cnt = CNT_THREE;
        end
        return seq;
    endfunction

endpackage

>>> src/cp1251_to_utf8.sv
// Windows-1251 to UTF-8 converter. Each input transfer carries one CP1251 byte;
// the block answers with one to three output transfers holding its UTF-8 bytes
// in order, o_last_byte high on the final one. ASCII gives one byte, Cyrillic
// and most symbols two, typographic marks (dashes, quotes, euro, trade mark,
// numero) three; the unassigned position 0x98 gives a single '?'. The output
// register gives one byte per cycle while i_out_ready is high. Input and output
// are parted by two register stages, so the next byte is taken while the current
// sequence is still draining; an input byte passes through the input register
// and then the output register before its first UTF-8 byte appears. There is no
// state beyond the pipeline itself and nothing to configure.
module cp1251_to_utf8 (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [c2u_pkg::BYTE_W-1:0] i_cp1251_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [c2u_pkg::BYTE_W-1:0] o_utf8_byte,
    output logic                       o_last_byte
);
    import c2u_pkg::*;

    // Input stage: one byte waiting for the encoder.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // Output stage: remaining bytes of the current sequence, head in r_seq.b0.
    logic      r_seq_valid;
    t_utf8_seq r_seq;
    t_utf8_seq n_seq;
    t_utf8_seq enc_seq;

    logic out_xfer;
    logic out_done;
    logic load_seq;

    assign enc_seq  = f_encode(r_in_byte);

    assign out_xfer = r_seq_valid && i_out_ready;
    assign out_done = out_xfer && (r_seq.cnt == CNT_ONE);
    // Move the input byte on when the output stage is empty or about to empty.
    assign load_seq = r_in_valid && (!r_seq_valid || out_done);

    assign o_in_ready  = !r_in_valid || load_seq;
    assign o_out_valid = r_seq_valid;
    assign o_utf8_byte = r_seq.b0;
    assign o_last_byte = (r_seq.cnt == CNT_ONE);

    // Next sequence contents: load fresh, shift one byte out, or hold.
    always_comb begin
        n_seq = r_seq;
        if (load_seq) begin
            n_seq = enc_seq;
        end else if (out_xfer && !out_done) begin
            n_seq.b0  = r_seq.b1;
            n_seq.b1  = r_seq.b2;
            n_seq.cnt = r_seq.cnt - CNT_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_seq_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (load_seq) begin
                r_seq_valid <= 1'b1;
            end else if (out_done) begin
                r_seq_valid <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_cp1251_byte;
        end
        r_seq <= n_seq;
    end

endmodule

>>> src/c2u_checker.sv
module c2u_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic [c2u_pkg::BYTE_W-1:0] i_cp1251_byte,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [c2u_pkg::BYTE_W-1:0] o_utf8_byte,
    input logic                       o_last_byte
);
    import c2u_pkg::*;

    // A stalled output byte holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_utf8_byte) && $stable(o_last_byte)))
        else $error("output byte changed while stalled");

    // A stalled input byte holds until the block takes it.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |=>
            (i_in_valid && $stable(i_cp1251_byte)))
        else $error("input byte changed while stalled");

    // A sequence continues without a bubble once started.
    a_seq_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_byte) |=>
            (o_out_valid && (o_utf8_byte[7:6] == 2'b10)))
        else $error("sequence broken after non-final byte");

    // A lead byte of a multi-byte sequence is never the final byte.
    a_lead_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_byte) |-> (o_utf8_byte[7:6] != 2'b11))
        else $error("lead byte marked as final");

    // A non-final byte never is plain ASCII.
    a_ascii_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_byte) |-> o_utf8_byte[7])
        else $error("ASCII byte not marked as final");

endmodule

bind cp1251_to_utf8 c2u_checker u_c2u_checker (.*);

>>> test/cp1251_checker.sv
`timescale 1ns / 100ps

module cp1251_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [c2u_pkg::BYTE_W-1:0] i_cp1251_byte,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [c2u_pkg::BYTE_W-1:0] i_utf8_byte,
    input  logic                       i_last_byte,
    output int                         o_mismatch_cnt,
    output int                         o_pending_cnt
);

    localparam int        REPORT_MAX      = 10;
    localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
    localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;

    // Code points for 0x80..0xFF; the hole at 0x98 is replaced by '?'.
    localparam logic [15:0] WIN1251_CP [128] = '{
        16'h0402, 16'h0403, 16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h20AC, 16'h2030, 16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F,
        16'h0452, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h003F, 16'h2122, 16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F,
        16'h00A0, 16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7,
        16'h0401, 16'h00A9, 16'h0404, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407,
        16'h00B0, 16'h00B1, 16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7,
        16'h0451, 16'h2116, 16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457,
        16'h0410, 16'h0411, 16'h0412, 16'h0413, 16'h0414, 16'h0415, 16'h0416, 16'h0417,
        16'h0418, 16'h0419, 16'h041A, 16'h041B, 16'h041C, 16'h041D, 16'h041E, 16'h041F,
        16'h0420, 16'h0421, 16'h0422, 16'h0423, 16'h0424, 16'h0425, 16'h0426, 16'h0427,
        16'h0428, 16'h0429, 16'h042A, 16'h042B, 16'h042C, 16'h042D, 16'h042E, 16'h042F,
        16'h0430, 16'h0431, 16'h0432, 16'h0433, 16'h0434, 16'h0435, 16'h0436, 16'h0437,
        16'h0438, 16'h0439, 16'h043A, 16'h043B, 16'h043C, 16'h043D, 16'h043E, 16'h043F,
        16'h0440, 16'h0441, 16'h0442, 16'h0443, 16'h0444, 16'h0445, 16'h0446, 16'h0447,
        16'h0448, 16'h0449, 16'h044A, 16'h044B, 16'h044C, 16'h044D, 16'h044E, 16'h044F
    };

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_utf8_out;

    t_utf8_out utf8_expect_q[$];
    t_utf8_out utf8_head;
    int        mismatch_cnt = 0;

    initial begin
        o_mismatch_cnt = 0;
        o_pending_cnt  = 0;
    end

    // Append one expected byte at the tail of the queue.
    function automatic void queue_expect(input logic [7:0] byte_val, input logic last_val);
        t_utf8_out item;
        item.data     = byte_val;
        item.last     = last_val;
        utf8_expect_q = {utf8_expect_q, item};
    endfunction

    // Queue the UTF-8 bytes one CP1251 character must produce.
    function automatic void encode_win1251(input logic [7:0] ch);
        logic [15:0] cp;
        cp = (ch < 8'h80) ? {8'h00, ch} : WIN1251_CP[ch[6:0]];
        if (cp < ONE_BYTE_LIMIT) begin
            queue_expect(cp[7:0], 1'b1);
        end else if (cp < TWO_BYTE_LIMIT) begin
            queue_expect({3'b110, cp[10:6]}, 1'b0);
            queue_expect({2'b10, cp[5:0]}, 1'b1);
        end else begin
            queue_expect({4'b1110, cp[15:12]}, 1'b0);
            queue_expect({2'b10, cp[11:6]}, 1'b0);
            queue_expect({2'b10, cp[5:0]}, 1'b1);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // Output first: a byte leaving now never belongs to a character taken now.
            if (i_out_valid && i_out_ready) begin
                if (utf8_expect_q.size() == 0) begin
                    if (mismatch_cnt < REPORT_MAX)
                        $display("%0t: unexpected output byte %02h last %b",
                                 $realtime, i_utf8_byte, i_last_byte);
                    mismatch_cnt = mismatch_cnt + 1;
                end else begin
                    utf8_head = utf8_expect_q.pop_front();
                    if (i_utf8_byte !== utf8_head.data || i_last_byte !== utf8_head.last) begin
                        if (mismatch_cnt < REPORT_MAX)
                            $display("%0t: expected byte %02h last %b, got byte %02h last %b",
                                     $realtime, utf8_head.data, utf8_head.last,
                                     i_utf8_byte, i_last_byte);
                        mismatch_cnt = mismatch_cnt + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                encode_win1251(i_cp1251_byte);
            o_mismatch_cnt <= mismatch_cnt;
            o_pending_cnt  <= utf8_expect_q.size();
        end
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    // Cycles with no transfer on either channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 3000;
    // Length of the forced output back-pressure window.
    localparam int HOLD_CYCLES    = 300;
    // Drain margin after the last expected byte has arrived.
    localparam int TAIL_CYCLES    = 12;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_cp1251_byte;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_utf8_byte;
    logic       o_last_byte;

    int mismatch_cnt;
    int pending_cnt;

    // Shared knobs: random idling on both sides, and a request for a long hold.
    bit idle_en  = 1'b1;
    bit hold_req = 1'b0;
    int quiet_cnt = 0;

    logic [7:0] directed_chars [21] = '{
        8'h00, 8'hFF, 8'h7F, 8'h80, 8'h41, 8'h98, 8'h99, 8'h82, 8'h88, 8'hB9, 8'hA0,
        8'hAA, 8'h55, 8'hC0, 8'hE0, 8'hBF, 8'h3F, 8'h96, 8'h97, 8'h98, 8'h01
    };

    always #1 i_clk = ~i_clk;

    // Drive every input to a known value from time zero.
    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_cp1251_byte = '0;
        i_out_ready   = 1'b0;
    end

    cp1251_to_utf8 uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cp1251_byte (i_cp1251_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_utf8_byte   (o_utf8_byte),
        .o_last_byte   (o_last_byte)
    );

    cp1251_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_cp1251_byte  (i_cp1251_byte),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_utf8_byte    (o_utf8_byte),
        .i_last_byte    (o_last_byte),
        .o_mismatch_cnt (mismatch_cnt),
        .o_pending_cnt  (pending_cnt)
    );

    // Pick a character: mostly Cyrillic and symbols, plenty of ASCII, and the
    // unassigned position often enough to hit it many times.
    function automatic logic [7:0] pick_char();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30)
            return 8'($urandom_range(8'h00, 8'h7F));
        else if (roll < 36)
            return 8'h98;
        else if (roll < 60)
            return 8'($urandom_range(8'h80, 8'hBF));
        else if (roll < 90)
            return 8'($urandom_range(8'hC0, 8'hFF));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // Offer one character and hold it until the block takes the transfer.
    // Called at a rising edge; returns at the edge that accepted the byte.
    task automatic send_char(input logic [7:0] ch);
        int gap;
        gap = (idle_en && $urandom_range(99) < 33) ? $urandom_range(1, 3) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cp1251_byte <= ch;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Output side: random stalls, plus one long hold on request so the
    // pipeline fills and pushes back on the input.
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            i_out_ready <= !(idle_en && $urandom_range(99) < 33);
        end
    end

    // Watchdog: count cycles in which nothing moves on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cnt <= 0;
        end else if (quiet_cnt >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("cp1251_to_utf8 test failed");
            $finish;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, every encoding length, the hole at 0x98.
        foreach (directed_chars[k])
            send_char(directed_chars[k]);

        // Random traffic with idling on both sides.
        repeat (200) send_char(pick_char());

        // Back-to-back stretch: no idling anywhere.
        idle_en = 1'b0;
        repeat (100) send_char(pick_char());
        idle_en = 1'b1;

        // Hold the output off while the sender keeps offering characters.
        hold_req = 1'b1;
        repeat (40) send_char(pick_char());

        repeat (140) send_char(pick_char());
        i_in_valid <= 1'b0;

        // Let the checker record the last push, then drain.
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && pending_cnt == 0) begin
            $display("cp1251_to_utf8 test passed");
        end else begin
            $display("cp1251_to_utf8 test failed");
        end
        $finish;
    end

endmodule

>>> files.f
src/c2u_pkg.sv
src/cp1251_to_utf8.sv
src/c2u_checker.sv
test/cp1251_checker.sv
test/tb_top.sv
